// ===== rtl/assert_macros.svh =====
// assertion helper macros for the voxel fuse and sample block
// used by the port checker; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tsdf_pkg.sv =====
// shared constants, codes and types for the voxel fuse and sample block
// no dependencies
package tsdf_pkg;

  // default grid size per axis
  localparam int SIZE_X_DEF = 64;
  localparam int SIZE_Y_DEF = 64;
  localparam int SIZE_Z_DEF = 64;

  // word widths
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // action codes
  localparam logic [1:0] ACT_FUSE   = 2'd0;
  localparam logic [1:0] ACT_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // status codes
  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_OUT  = 2'd1;
  localparam logic [1:0] STAT_SKIP = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_INV_X = 3'd0;
  localparam logic [2:0] CFG_INV_Y = 3'd1;
  localparam logic [2:0] CFG_INV_Z = 3'd2;
  localparam logic [2:0] CFG_POS_T = 3'd3;
  localparam logic [2:0] CFG_NEG_T = 3'd4;
  localparam logic [2:0] CFG_MAX_W = 3'd5;

  // register reset values
  localparam logic [15:0] INV_RST   = 16'd5461;
  localparam logic [14:0] POS_RST   = 15'd410;
  localparam logic [15:0] NEG_RST   = 16'hFE6D;
  localparam logic [15:0] MAXW_RST  = 16'hFFFF;

  // shared restoring divider widths
  localparam int DIV_RW = 50;
  localparam int DIV_DW = 34;
  localparam int DIV_QW = 17;

  typedef struct packed {
    logic                start;
    logic [DIV_RW-1:0]   num;
    logic [DIV_DW-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_QW-1:0]   quo;
  } div_rsp_t;

endpackage

// ===== rtl/tsdf_voxel_fuse_and_sample.sv =====
// top level of the voxel fuse and sample block: control, fuse math, interpolation
// depends on tsdf_pkg, tsdf_ram and tsdf_div
//
// Usage:
//   in_* carries one command word (tuser = action: fuse, sample, clear).
//   out_* returns exactly one result word per command (tuser = status).
//   cfg_* writes a register at any edge with cfg_we high.
// Steps from accept to result:
//   fuse: two 17-step passes through the shared divider, the weight
//   reciprocal, then the weighted average; a skipped or out-of-grid
//   fuse goes straight to the result;
//   sample: three coordinate multiplies, eight reads of the single ram
//   read port, seven lerps on one multiplier; the reads and lerps are
//   skipped when the point lies outside the volume;
//   clear: every one of the SIZE_X*SIZE_Y*SIZE_Z voxels, one voxel
//   written per cycle.
// One command is in work at a time; the next is taken once the block is
// idle, in the cycle after the result is loaded, even while the previous
// result still waits in the output register.
// Reset starts the same clearing pass with the default truncation;
// in_tready stays low until it ends, cfg is taken.
// A stalled receiver holds the result; the block finishes the next
// command and waits for the output register before loading it.
module tsdf_voxel_fuse_and_sample #(
  parameter int SIZE_X = tsdf_pkg::SIZE_X_DEF,
  parameter int SIZE_Y = tsdf_pkg::SIZE_Y_DEF,
  parameter int SIZE_Z = tsdf_pkg::SIZE_Z_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // voxel_x, voxel_y, voxel_z, measured_depth, voxel_cam_depth,
  // sample_x, sample_y, sample_z, zero pad
  input  logic [tsdf_pkg::IN_DATA_W-1:0]      in_tdata,
  // action
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // value, weight
  output logic [tsdf_pkg::OUT_DATA_W-1:0]     out_tdata,
  // status
  output logic [1:0]                          out_tuser,
  input  logic                                cfg_we,
  input  logic [tsdf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [tsdf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CELLS = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int AW    = $clog2(CELLS);
  localparam int SYZ   = SIZE_Y * SIZE_Z;
  localparam int XW    = $clog2(SIZE_X);
  localparam int YW    = $clog2(SIZE_Y);
  localparam int ZW    = $clog2(SIZE_Z);
  localparam int RW    = tsdf_pkg::DIV_RW;
  localparam int DW    = tsdf_pkg::DIV_DW;

  localparam logic [RW-1:0]        TWO32 = RW'(64'h1_0000_0000);
  localparam logic signed [34:0]   OFF_X = 35'(SIZE_X) << 19;
  localparam logic signed [34:0]   OFF_Y = 35'(SIZE_Y) << 19;
  localparam logic signed [34:0]   OFF_Z = 35'(SIZE_Z) << 19;

  // state codes
  localparam logic [3:0] S_SWEEP  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_F_ADDR = 4'd2;
  localparam logic [3:0] S_F_DATA = 4'd3;
  localparam logic [3:0] S_F_DIV1 = 4'd4;
  localparam logic [3:0] S_F_MUL  = 4'd5;
  localparam logic [3:0] S_F_SUM  = 4'd6;
  localparam logic [3:0] S_F_DIV2 = 4'd7;
  localparam logic [3:0] S_F_WAIT = 4'd8;
  localparam logic [3:0] S_F_WR   = 4'd9;
  localparam logic [3:0] S_S_MUL  = 4'd10;
  localparam logic [3:0] S_S_CHK  = 4'd11;
  localparam logic [3:0] S_S_ADDR = 4'd12;
  localparam logic [3:0] S_S_RD   = 4'd13;
  localparam logic [3:0] S_S_LERP = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  // configuration registers
  logic [15:0] inv_x_r, inv_y_r, inv_z_r, neg_r, maxw_r;
  logic [14:0] pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_x_r <= tsdf_pkg::INV_RST;
      inv_y_r <= tsdf_pkg::INV_RST;
      inv_z_r <= tsdf_pkg::INV_RST;
      pos_r   <= tsdf_pkg::POS_RST;
      neg_r   <= tsdf_pkg::NEG_RST;
      maxw_r  <= tsdf_pkg::MAXW_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tsdf_pkg::CFG_INV_X: inv_x_r <= cfg_wdata;
        tsdf_pkg::CFG_INV_Y: inv_y_r <= cfg_wdata;
        tsdf_pkg::CFG_INV_Z: inv_z_r <= cfg_wdata;
        tsdf_pkg::CFG_POS_T: pos_r   <= cfg_wdata[14:0];
        tsdf_pkg::CFG_NEG_T: neg_r   <= cfg_wdata;
        tsdf_pkg::CFG_MAX_W: maxw_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control registers
  logic [3:0]    state_r;
  logic [AW-1:0] sw_addr_r;
  logic [14:0]   sw_val_r;
  logic          sw_clr_r;
  logic [1:0]    ax_r;
  logic          out_any_r;
  logic [3:0]    rcnt_r;
  logic [2:0]    step_r;
  logic [2:0]    wpos_r;
  logic          out_valid_r;

  // command payload
  logic [5:0]  vx_r, vy_r, vz_r;
  logic [15:0] dp_r, cam_r, gx_r, gy_r, gz_r;

  // fuse datapath
  logic [33:0]        sq_r;
  logic signed [16:0] d_r;
  logic [15:0]        prev_r, wprev_r;
  logic [8:0]         w_r;
  logic signed [32:0] p1_r;
  logic signed [26:0] p2_r;
  logic signed [34:0] num_r;
  logic [16:0]        den_r;
  logic               neg_q_r;

  // sample datapath
  logic signed [32:0] prod_r;
  logic [XW-1:0]      i_r;
  logic [YW-1:0]      j_r;
  logic [ZW-1:0]      k_r;
  logic [15:0]        fx_r, fy_r, fz_r;
  logic [AW-1:0]      base_r;
  logic [15:0]        q_r [8];

  // result staging and output register
  logic [15:0] res_val_r, res_w_r;
  logic [1:0]  res_st_r;
  logic [31:0] out_data_r;
  logic [1:0]  out_user_r;

  // ram and divider hookup
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr, fidx;
  logic [31:0]   ram_wdata, ram_rdata;
  tsdf_pkg::div_req_t div_req;
  tsdf_pkg::div_rsp_t div_rsp;

  tsdf_ram #(.WIDTH(32), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tsdf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  function automatic logic [AW-1:0] corner_off(input logic [2:0] c);
    logic [AW-1:0] o;
    o = '0;
    if (c[2]) o = o + AW'(SYZ);
    if (c[1]) o = o + AW'(SIZE_Z);
    if (c[0]) o = o + AW'(1);
    return o;
  endfunction

  // fuse checks and voxel address
  logic signed [17:0] eta;
  logic               f_skip, f_out;
  logic [16:0]        base17;
  assign eta    = $signed({2'b00, dp_r}) - $signed({{2{cam_r[15]}}, cam_r});
  assign f_skip = (dp_r == '0) || (eta < $signed({{2{neg_r[15]}}, neg_r}));
  assign f_out  = (10'(vx_r) >= 10'(SIZE_X)) || (10'(vy_r) >= 10'(SIZE_Y)) ||
                  (10'(vz_r) >= 10'(SIZE_Z));
  assign fidx   = AW'(vx_r) * AW'(SYZ) + AW'(vy_r) * AW'(SIZE_Z) + AW'(vz_r);
  assign base17 = 17'(dp_r) + 17'd4096;

  // weighted average numerator magnitude
  logic signed [34:0] num_abs;
  assign num_abs = num_r[34] ? -num_r : num_r;

  // divider requests
  always_comb begin
    div_req.start = (state_r == S_F_DATA) || (state_r == S_F_DIV2);
    if (state_r == S_F_DATA) begin
      div_req.num = TWO32 + RW'(sq_r >> 1);
      div_req.den = DW'(sq_r);
    end else begin
      div_req.num = RW'(num_abs) + RW'(den_r >> 1);
      div_req.den = DW'(den_r);
    end
  end

  // fused value and capped weight
  logic [15:0] f_val, f_wn;
  assign f_val = neg_q_r ? 16'(-div_rsp.quo) : div_rsp.quo[15:0];
  assign f_wn  = (den_r > 17'(maxw_r)) ? maxw_r : den_r[15:0];

  // grid coordinate for the axis in work
  logic [15:0]        g_sel, inv_sel;
  logic signed [34:0] off_sel, p_ax;
  logic [14:0]        ip_ax;
  logic [9:0]         lim_sel;
  logic               ax_bad;
  always_comb begin
    unique case (ax_r)
      2'd0: begin
        g_sel = gx_r; inv_sel = inv_x_r; off_sel = OFF_X; lim_sel = 10'(SIZE_X - 1);
      end
      2'd1: begin
        g_sel = gy_r; inv_sel = inv_y_r; off_sel = OFF_Y; lim_sel = 10'(SIZE_Y - 1);
      end
      default: begin
        g_sel = gz_r; inv_sel = inv_z_r; off_sel = OFF_Z; lim_sel = 10'(SIZE_Z - 1);
      end
    endcase
  end
  assign p_ax   = 35'(prod_r) + off_sel;
  assign ip_ax  = p_ax[34:20];
  assign ax_bad = p_ax[34] || (ip_ax >= 15'(lim_sel));

  // one lerp step on the two head entries
  logic [15:0]        f_sel, lerp_res;
  logic signed [16:0] l_diff;
  logic signed [33:0] l_prod;
  always_comb begin
    priority if (step_r < 3'd4) f_sel = fz_r;
    else if (step_r < 3'd6)     f_sel = fy_r;
    else                        f_sel = fx_r;
  end
  assign l_diff   = $signed({q_r[1][15], q_r[1]}) - $signed({q_r[0][15], q_r[0]});
  assign l_prod   = l_diff * $signed({1'b0, f_sel}) + 34'sd32768;
  assign lerp_res = q_r[0] + 16'(l_prod >>> 16);

  // ram ports
  assign ram_we    = (state_r == S_SWEEP) || (state_r == S_F_WR);
  assign ram_waddr = (state_r == S_SWEEP) ? sw_addr_r : fidx;
  assign ram_wdata = (state_r == S_SWEEP) ? {16'd0, 1'b0, sw_val_r} : {f_wn, f_val};
  assign ram_raddr = (state_r == S_S_RD) ? base_r + corner_off(rcnt_r[2:0]) : fidx;

  assign in_tready = (state_r == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sw_addr_r   <= '0;
      sw_val_r    <= tsdf_pkg::POS_RST;
      sw_clr_r    <= 1'b0;
      ax_r        <= '0;
      out_any_r   <= 1'b0;
      rcnt_r      <= '0;
      step_r      <= '0;
      wpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result word taken, unless a new one is loaded in the same cycle
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_SWEEP: begin
          sw_addr_r <= sw_addr_r + 1'b1;
          if (sw_addr_r == AW'(CELLS - 1)) begin
            state_r <= sw_clr_r ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            priority case (in_tuser)
              tsdf_pkg::ACT_FUSE:   state_r <= S_F_ADDR;
              tsdf_pkg::ACT_SAMPLE: begin
                state_r   <= S_S_MUL;
                ax_r      <= '0;
                out_any_r <= 1'b0;
              end
              tsdf_pkg::ACT_CLEAR: begin
                state_r   <= S_SWEEP;
                sw_addr_r <= '0;
                sw_val_r  <= pos_r;
                sw_clr_r  <= 1'b1;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_F_ADDR: state_r <= (f_out || f_skip) ? S_DONE : S_F_DATA;
        S_F_DATA: state_r <= S_F_DIV1;
        S_F_DIV1: if (div_rsp.done) state_r <= S_F_MUL;
        S_F_MUL:  state_r <= S_F_SUM;
        S_F_SUM:  state_r <= S_F_DIV2;
        S_F_DIV2: state_r <= S_F_WAIT;
        S_F_WAIT: if (div_rsp.done) state_r <= S_F_WR;
        S_F_WR:   state_r <= S_DONE;
        S_S_MUL:  state_r <= S_S_CHK;
        S_S_CHK: begin
          if (ax_bad) out_any_r <= 1'b1;
          ax_r <= ax_r + 1'b1;
          state_r <= (ax_r == 2'd2) ? S_S_ADDR : S_S_MUL;
        end
        S_S_ADDR: begin
          rcnt_r  <= '0;
          state_r <= out_any_r ? S_DONE : S_S_RD;
        end
        S_S_RD: begin
          rcnt_r <= rcnt_r + 1'b1;
          if (rcnt_r == 4'd8) begin
            state_r <= S_S_LERP;
            step_r  <= '0;
            wpos_r  <= 3'd6;
          end
        end
        S_S_LERP: begin
          step_r <= step_r + 1'b1;
          wpos_r <= wpos_r - 1'b1;
          if (step_r == 3'd6) state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            sw_clr_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        vx_r  <= in_tdata[5:0];
        vy_r  <= in_tdata[11:6];
        vz_r  <= in_tdata[17:12];
        dp_r  <= in_tdata[33:18];
        cam_r <= in_tdata[49:34];
        gx_r  <= in_tdata[65:50];
        gy_r  <= in_tdata[81:66];
        gz_r  <= in_tdata[97:82];
        res_val_r <= '0;
        res_w_r   <= '0;
        res_st_r  <= tsdf_pkg::STAT_DONE;
      end
      S_SWEEP: begin
        res_val_r <= {1'b0, sw_val_r};
        res_w_r   <= '0;
        res_st_r  <= tsdf_pkg::STAT_DONE;
      end
      S_F_ADDR: begin
        sq_r <= 34'(base17) * 34'(base17);
        d_r  <= (eta > $signed({3'b000, pos_r})) ? $signed({2'b00, pos_r}) : 17'(eta);
        if (f_out) begin
          res_val_r <= {1'b0, pos_r};
          res_st_r  <= tsdf_pkg::STAT_OUT;
        end else if (f_skip) begin
          res_st_r  <= tsdf_pkg::STAT_SKIP;
        end
      end
      S_F_DATA: begin
        prev_r  <= ram_rdata[15:0];
        wprev_r <= ram_rdata[31:16];
      end
      S_F_DIV1: if (div_rsp.done) w_r <= div_rsp.quo[8:0];
      S_F_MUL: begin
        p1_r <= $signed(prev_r) * $signed({1'b0, wprev_r});
        p2_r <= d_r * $signed({1'b0, w_r});
      end
      S_F_SUM: begin
        num_r <= 35'(p1_r) + 35'(p2_r);
        den_r <= 17'(wprev_r) + 17'(w_r);
      end
      S_F_DIV2: neg_q_r <= num_r[34];
      S_F_WR: begin
        res_val_r <= f_val;
        res_w_r   <= f_wn;
        res_st_r  <= tsdf_pkg::STAT_DONE;
      end
      S_S_MUL: prod_r <= $signed(g_sel) * $signed({1'b0, inv_sel});
      S_S_CHK: begin
        unique case (ax_r)
          2'd0:    begin i_r <= ip_ax[XW-1:0]; fx_r <= p_ax[19:4]; end
          2'd1:    begin j_r <= ip_ax[YW-1:0]; fy_r <= p_ax[19:4]; end
          default: begin k_r <= ip_ax[ZW-1:0]; fz_r <= p_ax[19:4]; end
        endcase
      end
      S_S_ADDR: begin
        base_r    <= AW'(i_r) * AW'(SYZ) + AW'(j_r) * AW'(SIZE_Z) + AW'(k_r);
        res_val_r <= {1'b0, pos_r};
        res_st_r  <= tsdf_pkg::STAT_OUT;
      end
      S_S_RD: begin
        if (rcnt_r != 4'd0) begin
          for (int n = 0; n < 7; n++) q_r[n] <= q_r[n+1];
          q_r[7] <= ram_rdata[15:0];
        end
      end
      S_S_LERP: begin
        for (int n = 0; n < 8; n++) begin
          if (3'(n) == wpos_r) q_r[n] <= lerp_res;
          else if (n < 6)      q_r[n] <= q_r[n+2];
        end
        if (step_r == 3'd6) begin
          res_val_r <= lerp_res;
          res_st_r  <= tsdf_pkg::STAT_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_r <= {res_w_r, res_val_r};
          out_user_r <= res_st_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== rtl/tsdf_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
module tsdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tsdf_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on tsdf_pkg for widths and request/response types
module tsdf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  tsdf_pkg::div_req_t req,
  output tsdf_pkg::div_rsp_t rsp
);

  localparam int RW = tsdf_pkg::DIV_RW;
  localparam int QW = tsdf_pkg::DIV_QW;
  localparam int CW = $clog2(QW);

  logic [RW-1:0] rem_r;
  logic [RW-1:0] dsh_r;
  logic [QW-1:0] q_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic          ge;

  assign ge = rem_r >= dsh_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW-1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // datapath: compare, subtract, shift divisor down
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num;
      dsh_r <= RW'(req.den) << (QW-1);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= {q_r[QW-2:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;

endmodule

// ===== rtl/tsdf_chk.sv =====
// port checker for the voxel fuse and sample block, bound to the top level
// depends on assert_macros.svh and tsdf_pkg
`include "assert_macros.svh"

module tsdf_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tsdf_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                      out_tuser
);

  // a stalled result word holds
  `ASSERT_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // no status code beyond skipped
  `ASSERT_CLK(a_status_code, out_tvalid |-> (out_tuser == tsdf_pkg::STAT_DONE || out_tuser == tsdf_pkg::STAT_OUT || out_tuser == tsdf_pkg::STAT_SKIP), "unknown status")

  // only a completed command reports a weight
  `ASSERT_CLK(a_weight_zero, out_tvalid && out_tuser != tsdf_pkg::STAT_DONE |-> out_tdata[31:16] == 16'd0, "weight on skipped or outside result")

  // reset starts the clearing pass: a reset cycle is followed by no ready and no result word
  `ASSERT_ALWAYS(a_rst_sweep, !rst_n |=> !in_tready && !out_tvalid, "ready after reset")

endmodule

bind tsdf_voxel_fuse_and_sample tsdf_chk u_tsdf_chk (.*);

// ===== verif/tsdf_fuse_checker.sv =====
// result checker for the voxel fuse and sample block: predicts every result word
// from the accepted command words and register writes; depends on tsdf_pkg
module tsdf_fuse_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [tsdf_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [tsdf_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [1:0]                      out_tuser,
  input  logic                            cfg_we,
  input  logic [tsdf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tsdf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending
);
  import tsdf_pkg::*;

  localparam int CELLS = SIZE_X_DEF * SIZE_Y_DEF * SIZE_Z_DEF;

  typedef struct packed {
    logic [15:0] value;
    logic [15:0] weight;
    logic [1:0]  status;
  } voxel_result_t;

  // shadow grid and register copies
  logic [15:0] dist_grid [CELLS];
  logic [15:0] wgt_grid [CELLS];
  logic [15:0] inv_cell [3];
  logic [14:0] pos_t;
  logic [15:0] neg_t;
  logic [15:0] max_w;

  voxel_result_t expected_q[$];

  assign pending = expected_q.size();

  function automatic void clear_grid(logic [14:0] t);
    for (int i = 0; i < CELLS; i++) begin
      dist_grid[i] = {1'b0, t};
      wgt_grid[i] = 16'd0;
    end
  endfunction

  function automatic int lerp(int a, int b, logic [15:0] f);
    longint d;
    d = longint'(b - a) * longint'({48'd0, f}) + 64'sd32768;
    return a + int'(d >>> 16);
  endfunction

  // world coordinate to grid index and fraction; 0 when outside
  function automatic bit to_grid(logic [15:0] g, logic [15:0] inv, int size,
                                 output int idx, output logic [15:0] frac);
    longint p;
    p = longint'($signed(g)) * longint'({48'd0, inv}) + (longint'(size) <<< 19);
    idx = 0;
    frac = '0;
    if (p < 0) return 0;
    if ((p >>> 20) >= size - 1) return 0;
    idx = int'(p >>> 20);
    frac = p[19:4];
    return 1;
  endfunction

  function automatic int cell_at(int i, int j, int k);
    return $signed(dist_grid[i * SIZE_Y_DEF * SIZE_Z_DEF + j * SIZE_Z_DEF + k]);
  endfunction

  function automatic voxel_result_t predict_word(logic [1:0] act, logic [IN_DATA_W-1:0] d);
    voxel_result_t r;
    int eta, dd, prev, val, i, j, k, c00, c10, c01, c11, c0, c1;
    int unsigned idx;
    longint base, sq, w, wprev, num, den, mag, wn;
    logic [15:0] dp, fx, fy, fz;
    bit inx, iny, inz;
    r = '0;
    dp = d[33:18];
    case (act)
      ACT_FUSE: begin
        eta = int'({16'd0, dp}) - int'($signed(d[49:34]));
        if (dp == 16'd0 || eta < int'($signed(neg_t))) begin
          r.status = STAT_SKIP;
        end else begin
          idx = {d[5:0], d[11:6], d[17:12]};
          base = 64'sd4096 + longint'({48'd0, dp});
          sq = base * base;
          w = ((64'sd1 <<< 32) + sq / 2) / sq;
          dd = (eta > int'({17'd0, pos_t})) ? int'({17'd0, pos_t}) : eta;
          prev = $signed(dist_grid[idx]);
          wprev = longint'({48'd0, wgt_grid[idx]});
          num = longint'(prev) * wprev + longint'(dd) * w;
          den = wprev + w;
          mag = ((num < 0 ? -num : num) + den / 2) / den;
          wn = (den > longint'({48'd0, max_w})) ? longint'({48'd0, max_w}) : den;
          val = (num < 0) ? -int'(mag) : int'(mag);
          dist_grid[idx] = val[15:0];
          wgt_grid[idx] = wn[15:0];
          r.value = val[15:0];
          r.weight = wn[15:0];
          r.status = STAT_DONE;
        end
      end
      ACT_SAMPLE: begin
        inx = to_grid(d[65:50], inv_cell[0], SIZE_X_DEF, i, fx);
        iny = to_grid(d[81:66], inv_cell[1], SIZE_Y_DEF, j, fy);
        inz = to_grid(d[97:82], inv_cell[2], SIZE_Z_DEF, k, fz);
        if (!(inx && iny && inz)) begin
          r.value = {1'b0, pos_t};
          r.status = STAT_OUT;
        end else begin
          c00 = lerp(cell_at(i, j, k), cell_at(i, j, k + 1), fz);
          c10 = lerp(cell_at(i, j + 1, k), cell_at(i, j + 1, k + 1), fz);
          c01 = lerp(cell_at(i + 1, j, k), cell_at(i + 1, j, k + 1), fz);
          c11 = lerp(cell_at(i + 1, j + 1, k), cell_at(i + 1, j + 1, k + 1), fz);
          c0 = lerp(c00, c10, fy);
          c1 = lerp(c01, c11, fy);
          val = lerp(c0, c1, fx);
          r.value = val[15:0];
          r.status = STAT_DONE;
        end
      end
      ACT_CLEAR: begin
        clear_grid(pos_t);
        r.value = {1'b0, pos_t};
        r.status = STAT_DONE;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  initial begin
    fail_count = 0;
    inv_cell[0] = INV_RST;
    inv_cell[1] = INV_RST;
    inv_cell[2] = INV_RST;
    pos_t = POS_RST;
    neg_t = NEG_RST;
    max_w = MAXW_RST;
    clear_grid(POS_RST);
  end

  // register writes
  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      case (cfg_addr)
        CFG_INV_X: inv_cell[0] = cfg_wdata;
        CFG_INV_Y: inv_cell[1] = cfg_wdata;
        CFG_INV_Z: inv_cell[2] = cfg_wdata;
        CFG_POS_T: pos_t = cfg_wdata[14:0];
        CFG_NEG_T: neg_t = cfg_wdata;
        CFG_MAX_W: max_w = cfg_wdata;
        default: ;
      endcase
    end
  end

  // accepted command words
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expected_q.push_back(predict_word(in_tuser, in_tdata));
    end
  end

  // accepted result words
  always @(posedge clk) begin
    voxel_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $error("result word with no command waiting: value %0h weight %0h status %0d",
               out_tdata[15:0], out_tdata[31:16], out_tuser);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (out_tdata[15:0] !== e.value) begin
          $error("value expected %0d actual %0d", $signed(e.value), $signed(out_tdata[15:0]));
          fail_count++;
        end
        if (out_tdata[31:16] !== e.weight) begin
          $error("weight expected %0d actual %0d", e.weight, out_tdata[31:16]);
          fail_count++;
        end
        if (out_tuser !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_tuser);
          fail_count++;
        end
      end
    end
  end

endmodule

// ===== verif/tb_tsdf_voxel_fuse_and_sample.sv =====
// testbench top for the voxel fuse and sample block: clock, reset, command and
// register stimulus, receiver stalls; depends on tsdf_pkg and tsdf_fuse_checker
module tb_tsdf_voxel_fuse_and_sample;
  import tsdf_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int PHASE_ITEMS = 145;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    cycles;
  int                    words_taken;
  logic [15:0]           cur_inv [3];

  tsdf_voxel_fuse_and_sample i_dut (.*);

  tsdf_fuse_checker i_checker (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int n;
    out_tready = 1'b0;
    words_taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = (words_taken == 250) ? 3000 : $urandom_range(0, 6);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      words_taken++;
    end
  end

  task automatic send_word(input logic [1:0] act, input logic [IN_DATA_W-1:0] d);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [IN_DATA_W-1:0] pack_word(logic [5:0] vx, logic [5:0] vy,
                                                     logic [5:0] vz,
                                                     logic [15:0] dp, logic [15:0] cam,
                                                     logic [15:0] sx, logic [15:0] sy,
                                                     logic [15:0] sz);
    return {6'd0, sz, sy, sx, cam, dp, vz, vy, vx};
  endfunction

  task automatic send_fuse(int vx, int vy, int vz, int dp, int cam);
    send_word(ACT_FUSE, pack_word(vx[5:0], vy[5:0], vz[5:0], dp[15:0], cam[15:0],
                                  16'($urandom()), 16'($urandom()), 16'($urandom())));
  endtask

  task automatic send_sample(int sx, int sy, int sz);
    send_word(ACT_SAMPLE, pack_word(6'($urandom()), 6'($urandom()), 6'($urandom()),
                                    16'($urandom()), 16'($urandom()),
                                    sx[15:0], sy[15:0], sz[15:0]));
  endtask

  // world coordinate that lands near a random voxel from 27 to 36 under the current scale
  function automatic int aim_at(int axis);
    longint g;
    int t;
    t = $urandom_range(27, 36);
    if (cur_inv[axis] == 16'd0) return $urandom_range(0, 65535) - 32768;
    g = ((longint'(t - 32) <<< 20) + longint'($urandom_range(0, 1048575)))
        / longint'({48'd0, cur_inv[axis]});
    if (g > 32767) g = 32767;
    if (g < -32768) g = -32768;
    return int'(g);
  endfunction

  // drop the offer, then wait for every result to drain
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] ix, logic [15:0] iy, logic [15:0] iz,
                            logic [14:0] pt, logic [15:0] nt, logic [15:0] mw);
    logic [15:0] vals [6];
    vals = '{ix, iy, iz, {1'b0, pt}, nt, mw};
    in_tvalid <= 1'b0;
    for (int r = 0; r < 6; r++) begin
      cfg_we <= 1'b1;
      cfg_addr <= r[2:0];
      cfg_wdata <= vals[r];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_inv = '{ix, iy, iz};
  endtask

  task automatic random_phase();
    int dp, cam, sel;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        dp = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(500, 24000);
        cam = dp - $urandom_range(0, 1800) + 600;
        if (cam > 32767) cam = 32767;
        if (cam < -32768) cam = -32768;
        send_fuse($urandom_range(27, 37), $urandom_range(27, 37), $urandom_range(27, 37),
                  dp, cam);
      end else if (sel < 80) begin
        send_sample(aim_at(0), aim_at(1), aim_at(2));
      end else if (sel < 88) begin
        send_fuse($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else if (sel < 96) begin
        send_sample($urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535));
      end else begin
        send_word(ACT_UNUSED, IN_DATA_W'({$urandom(), $urandom(), $urandom(), $urandom()}));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    cur_inv = '{INV_RST, INV_RST, INV_RST};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: skips, clamp, extremes, averaging, samples, unused action, clear
    send_fuse(32, 32, 32, 0, 0);
    send_fuse(32, 32, 32, 1, 32767);
    send_fuse(32, 32, 32, 8000, 2000);
    send_fuse(32, 32, 33, 4096, 4000);
    send_fuse(32, 32, 33, 4096, 4100);
    send_fuse(32, 33, 32, 1, 1);
    send_fuse(63, 63, 63, 65535, -32768);
    send_fuse(0, 0, 0, 65535, 32767);
    send_fuse(33, 32, 32, 2000, 2300);
    send_sample(0, 0, 0);
    send_sample(100, 200, 300);
    send_sample(-32768, 0, 0);
    send_sample(32767, 32767, 32767);
    send_sample(0, -32768, 0);
    send_sample(0, 0, 32767);
    send_word(ACT_UNUSED, '1);
    send_word(ACT_CLEAR, '0);
    send_sample(100, 200, 300);
    send_fuse(32, 32, 32, 3000, 2990);
    send_sample(50, 50, 50);
    random_phase();

    wait_idle();
    write_regs(16'd2048, 16'd2048, 16'd2048, 15'd32767, 16'h8000, 16'hFFFF);
    random_phase();

    wait_idle();
    write_regs(16'd65535, 16'd1, 16'd0, 15'd0, 16'd0, 16'd0);
    random_phase();

    wait_idle();
    write_regs(16'($urandom_range(1000, 20000)), 16'($urandom_range(1000, 20000)),
               16'($urandom_range(1000, 20000)), 15'($urandom_range(0, 32767)),
               16'(-$urandom_range(0, 32768)), 16'd300);
    random_phase();

    wait_idle();
    write_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
               16'($urandom_range(1, 65535)), 15'($urandom_range(0, 32767)),
               16'(-$urandom_range(0, 32768)), 16'($urandom_range(0, 65535)));
    random_phase();

    wait_idle();
    write_regs(INV_RST, INV_RST, INV_RST, POS_RST, NEG_RST, MAXW_RST);
    random_phase();

    wait_idle();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tsdf_pkg.sv
rtl/tsdf_ram.sv
rtl/tsdf_div.sv
rtl/tsdf_voxel_fuse_and_sample.sv
rtl/tsdf_chk.sv
verif/tsdf_fuse_checker.sv
verif/tb_tsdf_voxel_fuse_and_sample.sv
